[rtl/ubxd_pkg.sv]
`default_nettype none
package ubxd_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h62;
    localparam logic [15:0] MAX_LEN_RESET   = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_DONE    = 2'd1,
        K_LEN_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] payload_length;
        logic        checksum_ok;
        logic [15:0] received_checksum;
    } t_ubxd_res;

endpackage
`default_nettype wire

[rtl/ubxd_parser.sv]
`default_nettype none
module ubxd_parser
    import ubxd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [15:0] i_max_len,
    output logic             o_res_valid,
    output t_ubxd_res        o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_ck_a, n_ck_a;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic        hit;
    t_ubxd_res   res;

    assign add_a    = r_sum_a + i_rx_byte;
    assign add_b    = r_sum_b + add_a;
    assign len_full = {i_rx_byte, r_len[7:0]};
    assign cnt_inc  = r_count + 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_count = r_count;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;
        hit     = 1'b0;
        res.kind              = K_PAYLOAD;
        res.msg_class         = r_class;
        res.msg_id            = r_id;
        res.payload_byte      = '0;
        res.byte_index        = '0;
        res.payload_length    = r_len;
        res.checksum_ok       = 1'b0;
        res.received_checksum = '0;
        case (r_phase)
            PH_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                end else begin
                    n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum_a = i_rx_byte;
                n_sum_b = i_rx_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, i_rx_byte};
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = len_full;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_count = '0;
                if (len_full > i_max_len) begin
                    hit                = 1'b1;
                    res.kind           = K_LEN_ERR;
                    res.payload_length = len_full;
                    n_phase            = PH_SYNC1;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a          = add_a;
                n_sum_b          = add_b;
                hit              = 1'b1;
                res.kind         = K_PAYLOAD;
                res.payload_byte = i_rx_byte;
                res.byte_index   = r_count;
                n_count          = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                n_ck_a  = i_rx_byte;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                hit                   = 1'b1;
                res.kind              = K_DONE;
                res.checksum_ok       = (r_ck_a == r_sum_a) && (i_rx_byte == r_sum_b);
                res.received_checksum = {i_rx_byte, r_ck_a};
                n_phase               = PH_SYNC1;
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_class <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_ck_a  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
        end
    end

    assign o_res_valid = i_take && hit;
    assign o_res       = res;

endmodule
`default_nettype wire

[rtl/ubx_frame_deframer_unit.sv]
`default_nettype none
// Channel   Direction  Handshake                  Payload
// rx        in         i_rx_valid / o_rx_ready    i_rx_byte
// res       out        o_res_valid / i_res_ready  o_kind .. o_received_checksum
// cfg       in         i_cfg_we                   i_cfg_wdata (max payload length)
//
// One byte is accepted per cycle while o_rx_ready is high; a result is registered
// in the output register, or in the skid register while that one holds an untaken result.
// A skid register behind the output register lets a byte be taken while one
// result waits; o_rx_ready drops only when both hold results.
// Synchronous active-low reset returns the parser to sync hunting and sets the
// length limit to 65535.
module ubx_frame_deframer_unit
    import ubxd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_id,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_byte_index,
    output logic [15:0]      o_payload_length,
    output logic             o_checksum_ok,
    output logic [15:0]      o_received_checksum
);

    logic [15:0] r_max_len;
    logic        take;
    logic        push;
    logic        pop;
    t_ubxd_res   push_res;
    logic        r_out_valid;
    t_ubxd_res   r_out;
    logic        r_skd_valid;
    t_ubxd_res   r_skd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    assign o_rx_ready = !r_skd_valid;
    assign take       = i_rx_valid && o_rx_ready;
    assign pop        = r_out_valid && i_res_ready;

    ubxd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (push),
        .o_res       (push_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (pop) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= push_res;
            end else begin
                r_skd <= push_res;
            end
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_kind              = r_out.kind;
    assign o_msg_class         = r_out.msg_class;
    assign o_msg_id            = r_out.msg_id;
    assign o_payload_byte      = r_out.payload_byte;
    assign o_byte_index        = r_out.byte_index;
    assign o_payload_length    = r_out.payload_length;
    assign o_checksum_ok       = r_out.checksum_ok;
    assign o_received_checksum = r_out.received_checksum;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds an item while output register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> !push)
        else $error("result produced while both output stages are full");

    a_payload_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind != K_PAYLOAD) |-> (o_payload_byte == 8'd0
            && o_byte_index == 16'd0))
        else $error("payload fields set on a non-payload item");

    a_index_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == K_PAYLOAD) |-> (o_byte_index < o_payload_length))
        else $error("payload index at or beyond declared length");

endmodule
`default_nettype wire
